// ===== rtl/hnu_pkg.sv =====
`default_nettype none
package hnu_pkg;

   localparam int NEURONS     = 4096;
   localparam int ADDR_W      = $clog2(NEURONS);
   localparam int NUM_ACT     = 10;
   localparam int ACT_W       = 16;
   localparam int IDX_W       = 12;
   localparam int W_W         = 32;
   localparam int SIG_ENTRIES = 256;
   localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
   localparam int SIG_SHIFT   = 17 - SIG_IDX_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int ROW_W       = NUM_ACT * W_W;
   localparam int TF_W        = 2 * W_W;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FATIGUE_DECAY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FATIGUE_TARGET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_TARGET    = 3'd3;

   localparam logic [15:0] LEARN_RATE_RST     = 16'd655;
   localparam logic [15:0] FATIGUE_DECAY_RST  = 16'd62259;
   localparam logic [23:0] FATIGUE_TARGET_RST = 24'd174763;
   localparam logic [15:0] NORM_TARGET_RST    = 16'd13107;

   typedef struct packed {
      logic [15:0] learn_rate;
      logic [15:0] fatigue_decay;
      logic [23:0] fatigue_target;
      logic [15:0] norm_target;
   } hnu_cfg_type;

   typedef struct packed {
      logic                             valid;
      logic [ADDR_W-1:0]                addr;
      logic [NUM_ACT-1:0][W_W-1:0]      w;
      logic [NUM_ACT-1:0][ACT_W-1:0]    a;
      logic [ACT_W-1:0]                 exc;
      logic [W_W-1:0]                   th;
      logic [W_W-1:0]                   fat;
   } hnu_launch_type;

   typedef struct packed {
      logic                             we;
      logic [ADDR_W-1:0]                addr;
      logic [NUM_ACT-1:0][W_W-1:0]      w;
      logic [W_W-1:0]                   th;
      logic [W_W-1:0]                   fat;
      logic                             busy;
   } hnu_wb_type;

   typedef logic [15:0] sig_rom_type [SIG_ENTRIES];

   // shift and subtract quotient for table build
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg(input logic [63:0] u);
      logic [63:0]        f;
      logic [63:0]        term;
      logic [63:0]        s;
      logic signed [63:0] acc;
      f    = u >> 4;
      term = 64'd1 << 32;
      acc  = 64'sd1 <<< 32;
      for (int n = 1; n <= 14; n++) begin
         term = udiv64((term * f) >> 32, 64'(n));
         if ((n & 1) == 1) acc = acc - $signed(term);
         else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 64'sd0;
      if (acc > 64'sh00000000FFFFFFFF) acc = 64'sh00000000FFFFFFFF;
      s = $unsigned(acc);
      for (int k = 0; k < 4; k++) s = (s * s) >> 32;
      return s;
   endfunction

   function automatic sig_rom_type sig_build();
      sig_rom_type        rom;
      logic signed [63:0] d;
      logic [63:0]        mag;
      logic [63:0]        u;
      logic [63:0]        e;
      logic [63:0]        den;
      logic [63:0]        s;
      for (int i = 0; i < SIG_ENTRIES; i++) begin
         d   = 64'sd20 * 64'(i) - 64'sd10 * 64'(SIG_ENTRIES);
         mag = (d < 0) ? $unsigned(-d) : $unsigned(d);
         u   = (mag << 32) >> SIG_IDX_W;
         e   = exp_neg(u);
         den = (64'd1 << 32) + e;
         s   = (d >= 0) ? udiv64(64'd1 << 48, den) : udiv64(e << 16, den);
         if (s > 64'd65535) s = 64'd65535;
         rom[i] = s[15:0];
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = sig_build();

endpackage
`default_nettype wire

// ===== rtl/hnu_ifs.sv =====
`default_nettype none
interface hnu_req_if;
   import hnu_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [IDX_W-1:0]    neuron_index;
   logic [ACT_W-1:0]    motor_act_0;
   logic [ACT_W-1:0]    motor_act_1;
   logic [ACT_W-1:0]    motor_act_2;
   logic [ACT_W-1:0]    motor_act_3;
   logic [ACT_W-1:0]    motor_act_4;
   logic [ACT_W-1:0]    visual_act_0;
   logic [ACT_W-1:0]    visual_act_1;
   logic [ACT_W-1:0]    visual_act_2;
   logic [ACT_W-1:0]    visual_act_3;
   logic [ACT_W-1:0]    visual_act_4;
   modport source (output valid, op, neuron_index, motor_act_0, motor_act_1, motor_act_2,
                   motor_act_3, motor_act_4, visual_act_0, visual_act_1, visual_act_2,
                   visual_act_3, visual_act_4, input ready);
   modport sink (input valid, op, neuron_index, motor_act_0, motor_act_1, motor_act_2,
                 motor_act_3, motor_act_4, visual_act_0, visual_act_1, visual_act_2,
                 visual_act_3, visual_act_4, output ready);
endinterface

interface hnu_rsp_if;
   import hnu_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    result_index;
   logic [ACT_W-1:0]    excitation;
   logic                clamped;
   modport source (output valid, result_index, excitation, clamped, input ready);
   modport sink (input valid, result_index, excitation, clamped, output ready);
endinterface

interface hnu_csr_if;
   import hnu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hnu_ram.sv =====
`default_nettype none
module hnu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/hnu_learn.sv =====
`default_nettype none
module hnu_learn (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hnu_pkg::hnu_cfg_type   cfg,
   input  wire hnu_pkg::hnu_launch_type launch,
   output hnu_pkg::hnu_wb_type         wb
);
   import hnu_pkg::*;

   localparam int QW    = 52;
   localparam int REM_W = 36;
   localparam int CNT_W = $clog2(QW);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_PREP = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_WB   = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [NUM_ACT-1:0][W_W-1:0]   w_ff;
   logic [NUM_ACT-1:0][ACT_W-1:0] a_ff;
   logic [NUM_ACT-1:0][W_W-1:0]   t_ff;
   logic [NUM_ACT-1:0][QW-1:0]    mag_ff;
   logic [NUM_ACT-1:0][REM_W-1:0] rem_ff;
   logic [NUM_ACT-1:0]            neg_ff;
   logic [ACT_W-1:0]            exc_ff;
   logic [W_W-1:0]              th_ff;
   logic [W_W-1:0]              fat_ff;
   logic [ADDR_W-1:0]           addr_ff;
   logic [47:0]                 fp_ff;
   logic signed [35:0]          s_ff;
   logic signed [50:0]          dp_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [19:0]                 scale;

   assign scale = 20'({4'd0, cfg.norm_target} * 20'd10);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (launch.valid) state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_SUM;
         S_SUM:  state_in = S_PREP;
         S_PREP: state_in = (s_ff > 36'sd0) ? S_DIV : S_WB;
         S_DIV:  if (cnt_ff == CNT_W'(QW - 1)) state_in = S_FIN;
         S_FIN:  state_in = S_WB;
         S_WB:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      logic [47:0]        tp;
      logic signed [32:0] wsum;
      logic [32:0]        fsum;
      logic signed [35:0] acc;
      logic signed [35:0] thn;
      logic signed [52:0] prod;
      logic [REM_W-1:0]   trial;
      logic [QW-1:0]      q;
      case (state_ff)
         S_IDLE: begin
            w_ff    <= launch.w;
            a_ff    <= launch.a;
            exc_ff  <= launch.exc;
            th_ff   <= launch.th;
            fat_ff  <= launch.fat;
            addr_ff <= launch.addr;
         end
         S_MUL1: begin
            for (int i = 0; i < NUM_ACT; i++) t_ff[i] <= a_ff[i] * exc_ff;
            fp_ff <= fat_ff * cfg.fatigue_decay;
         end
         S_MUL2: begin
            for (int i = 0; i < NUM_ACT; i++) begin
               tp   = t_ff[i] * cfg.learn_rate;
               wsum = $signed({w_ff[i][W_W-1], w_ff[i]}) + $signed({17'd0, tp[47:32]});
               if (!wsum[32] && wsum[31]) w_ff[i] <= 32'h7FFFFFFF;
               else w_ff[i] <= wsum[31:0];
            end
            fsum = {1'b0, fp_ff[47:16]} + {17'd0, exc_ff};
            fat_ff <= fsum[32] ? 32'hFFFFFFFF : fsum[31:0];
         end
         S_SUM: begin
            acc = 36'sd0;
            for (int i = 0; i < NUM_ACT; i++) acc = acc + 36'($signed(w_ff[i]));
            s_ff  <= acc;
            dp_ff <= 51'(($signed({2'b0, fat_ff}) - $signed({10'd0, cfg.fatigue_target}))
                     * $signed({1'b0, cfg.learn_rate}));
         end
         S_PREP: begin
            thn = 36'($signed(th_ff)) + 36'(dp_ff >>> 16);
            if (thn > 36'sh07FFFFFFF) th_ff <= 32'h7FFFFFFF;
            else if (thn < -36'sh080000000) th_ff <= 32'h80000000;
            else th_ff <= thn[31:0];
            for (int i = 0; i < NUM_ACT; i++) begin
               prod = $signed(w_ff[i]) * $signed({1'b0, scale});
               neg_ff[i] <= prod[52];
               mag_ff[i] <= prod[52] ? QW'(-prod) : prod[QW-1:0];
               rem_ff[i] <= '0;
            end
            cnt_ff <= '0;
         end
         S_DIV: begin
            for (int i = 0; i < NUM_ACT; i++) begin
               trial = {rem_ff[i][REM_W-2:0], mag_ff[i][QW-1]};
               if (trial >= $unsigned(s_ff)) begin
                  rem_ff[i] <= trial - $unsigned(s_ff);
                  mag_ff[i] <= {mag_ff[i][QW-2:0], 1'b1};
               end else begin
                  rem_ff[i] <= trial;
                  mag_ff[i] <= {mag_ff[i][QW-2:0], 1'b0};
               end
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         S_FIN: begin
            for (int i = 0; i < NUM_ACT; i++) begin
               q = mag_ff[i];
               if (neg_ff[i]) begin
                  if (q > QW'(64'h80000000)) w_ff[i] <= 32'h80000000;
                  else w_ff[i] <= 32'(-q);
               end else begin
                  if (q > QW'(64'h7FFFFFFF)) w_ff[i] <= 32'h7FFFFFFF;
                  else w_ff[i] <= q[31:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign wb.we   = (state_ff == S_WB);
   assign wb.addr = addr_ff;
   assign wb.w    = w_ff;
   assign wb.th   = th_ff;
   assign wb.fat  = fat_ff;
   assign wb.busy = (state_ff != S_IDLE);

   a_launch_idle: assert property (@(posedge clock) disable iff (reset)
      launch.valid |-> state_ff == S_IDLE)
      else $error("launch while engine busy");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> $past(cnt_ff) == CNT_W'(QW - 1))
      else $error("divider ended early");
   a_wb_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |=> state_ff == S_IDLE)
      else $error("write-back not followed by idle");
endmodule
`default_nettype wire

// ===== rtl/hebbian_neuron_update.sv =====
// results reach rsp through the read, product, index and response registers
// evaluate items: one per cycle while rsp is ready and no learn or clear runs
// learn items: hold off new items until written back; they run the bit-serial
// rescale divider (ten lanes, one quotient bit per cycle) and row write-back
// reset: clears config to defaults, then zeroes all 4096 rows of both memories
`default_nettype none
module hebbian_neuron_update (
   input  wire logic clock,
   input  wire logic reset,
   hnu_req_if.sink   req_ch,
   hnu_rsp_if.source rsp_ch,
   hnu_csr_if.sink   csr_ch
);
   import hnu_pkg::*;

   hnu_cfg_type cfg_ff;

   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic adv, accept, learn_busy;

   logic [NUM_ACT-1:0][ACT_W-1:0] act_in;

   logic                           v1_ff, op1_ff;
   logic [IDX_W-1:0]               idx1_ff;
   logic [NUM_ACT-1:0][ACT_W-1:0]  act1_ff;

   logic                           v2_ff, op2_ff;
   logic [IDX_W-1:0]               idx2_ff;
   logic [NUM_ACT-1:0][ACT_W-1:0]  act2_ff;
   logic [NUM_ACT-1:0][W_W-1:0]    w2_ff;
   logic [W_W-1:0]                 th2_ff, fat2_ff;
   logic [NUM_ACT-1:0][48:0]       prod2_ff;

   logic                           v3_ff, op3_ff, cl3_ff;
   logic [IDX_W-1:0]               idx3_ff;
   logic [NUM_ACT-1:0][ACT_W-1:0]  act3_ff;
   logic [NUM_ACT-1:0][W_W-1:0]    w3_ff;
   logic [W_W-1:0]                 th3_ff, fat3_ff;
   logic [SIG_IDX_W-1:0]           ri3_ff;

   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_idx_ff;
   logic [ACT_W-1:0]      rsp_exc_ff;
   logic                  rsp_cl_ff;

   logic [ROW_W-1:0]  w_rdata, w_wdata;
   logic [TF_W-1:0]   tf_rdata, tf_wdata;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;

   logic [ACT_W-1:0]     exc3;
   logic [SIG_IDX_W-1:0] ri_in;
   logic                 cl_in;

   hnu_launch_type launch;
   hnu_wb_type     wb;

   assign act_in = {req_ch.visual_act_4, req_ch.visual_act_3, req_ch.visual_act_2,
                    req_ch.visual_act_1, req_ch.visual_act_0, req_ch.motor_act_4,
                    req_ch.motor_act_3, req_ch.motor_act_2, req_ch.motor_act_1,
                    req_ch.motor_act_0};

   assign adv        = !rsp_valid_ff || rsp_ch.ready;
   assign learn_busy = (v1_ff && op1_ff) || (v2_ff && op2_ff) || (v3_ff && op3_ff) || wb.busy;
   assign req_ch.ready = adv && !learn_busy && !clr_busy_ff;
   assign accept     = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate     <= LEARN_RATE_RST;
         cfg_ff.fatigue_decay  <= FATIGUE_DECAY_RST;
         cfg_ff.fatigue_target <= FATIGUE_TARGET_RST;
         cfg_ff.norm_target    <= NORM_TARGET_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_LEARN_RATE:     cfg_ff.learn_rate     <= csr_ch.data[15:0];
            CSR_FATIGUE_DECAY:  cfg_ff.fatigue_decay  <= csr_ch.data[15:0];
            CSR_FATIGUE_TARGET: cfg_ff.fatigue_target <= csr_ch.data[23:0];
            CSR_NORM_TARGET:    cfg_ff.norm_target    <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end

   // memory clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_W'(NEURONS - 1)) clr_busy_ff <= 1'b0;
      end
   end

   assign mem_we    = clr_busy_ff || wb.we;
   assign mem_waddr = clr_busy_ff ? clr_cnt_ff : wb.addr;
   assign w_wdata   = clr_busy_ff ? '0 : wb.w;
   assign tf_wdata  = clr_busy_ff ? '0 : {wb.fat, wb.th};

   hnu_ram #(.WIDTH(ROW_W), .DEPTH(NEURONS)) u_wram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (w_wdata),
      .re    (accept),
      .raddr (req_ch.neuron_index[ADDR_W-1:0]),
      .rdata (w_rdata)
   );

   hnu_ram #(.WIDTH(TF_W), .DEPTH(NEURONS)) u_tfram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (tf_wdata),
      .re    (accept),
      .raddr (req_ch.neuron_index[ADDR_W-1:0]),
      .rdata (tf_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // pipeline registers and weighted-sum products
   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff  <= req_ch.op;
         idx1_ff <= req_ch.neuron_index;
         act1_ff <= act_in;

         op2_ff  <= op1_ff;
         idx2_ff <= idx1_ff;
         act2_ff <= act1_ff;
         w2_ff   <= w_rdata;
         th2_ff  <= tf_rdata[W_W-1:0];
         fat2_ff <= tf_rdata[TF_W-1:W_W];
         for (int i = 0; i < NUM_ACT; i++)
            prod2_ff[i] <= $signed(w_rdata[i*W_W +: W_W]) * $signed({1'b0, act1_ff[i]});

         op3_ff  <= op2_ff;
         idx3_ff <= idx2_ff;
         act3_ff <= act2_ff;
         w3_ff   <= w2_ff;
         th3_ff  <= th2_ff;
         fat3_ff <= fat2_ff;
         ri3_ff  <= ri_in;
         cl3_ff  <= cl_in;

         rsp_idx_ff <= idx3_ff;
         rsp_exc_ff <= exc3;
         rsp_cl_ff  <= cl3_ff;
      end
   end

   // sum, threshold and table index
   always_comb begin
      logic signed [52:0] acc;
      logic signed [37:0] off;
      logic [37:0]        q;
      acc = 53'sd0;
      for (int i = 0; i < NUM_ACT; i++) acc = acc + 53'($signed(prod2_ff[i]));
      off = 38'(acc >>> 16) - 38'($signed(th2_ff)) + 38'sd32768;
      q   = $unsigned(off) >> SIG_SHIFT;
      if (off < 0) begin
         ri_in = '0;
         cl_in = 1'b1;
      end else if (q >= 38'(SIG_ENTRIES)) begin
         ri_in = SIG_IDX_W'(SIG_ENTRIES - 1);
         cl_in = 1'b1;
      end else begin
         ri_in = q[SIG_IDX_W-1:0];
         cl_in = 1'b0;
      end
   end

   assign exc3 = SIG_ROM[ri3_ff];

   assign launch.valid = v3_ff && op3_ff && adv;
   assign launch.addr  = idx3_ff[ADDR_W-1:0];
   assign launch.w     = w3_ff;
   assign launch.a     = act3_ff;
   assign launch.exc   = exc3;
   assign launch.th    = th3_ff;
   assign launch.fat   = fat3_ff;

   hnu_learn u_learn (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .launch (launch),
      .wb     (wb)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_index = rsp_idx_ff;
   assign rsp_ch.excitation   = rsp_exc_ff;
   assign rsp_ch.clamped      = rsp_cl_ff;

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clr_busy_ff && !wb.busy)
      else $error("item accepted during clear or learn");
   a_wb_not_clear: assert property (@(posedge clock) disable iff (reset)
      wb.we |-> !clr_busy_ff)
      else $error("write-back during clearing pass");
   a_one_learn: assert property (@(posedge clock) disable iff (reset)
      $countones({v1_ff && op1_ff, v2_ff && op2_ff, v3_ff && op3_ff, wb.busy}) <= 1)
      else $error("two learn items in flight");
endmodule
`default_nettype wire
